>>> src/ffha_pkg.sv
// ffha_pkg: command and status codes and field widths of the first-fit heap allocator.
// Used by first_fit_heap_allocator and ffha_checker; depends on nothing.
package ffha_pkg;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned ReqW  = 13;
  localparam int unsigned OffW  = 12;
  localparam int unsigned StatW = 3;
  // rounded request in 8-byte units: (8191 + 7) >> 3 needs 11 bits
  localparam int unsigned UnitW = 11;

  localparam logic [CmdW-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CmdW-1:0] CMD_FREE  = 2'd1;
  localparam logic [CmdW-1:0] CMD_QUERY = 2'd2;

  localparam logic [StatW-1:0] ST_OK      = 3'd0;
  localparam logic [StatW-1:0] ST_ZERO    = 3'd1;
  localparam logic [StatW-1:0] ST_NOSPACE = 3'd2;
  localparam logic [StatW-1:0] ST_FREED   = 3'd3;
  localparam logic [StatW-1:0] ST_NOTHEAP = 3'd4;

endpackage

>>> src/first_fit_heap_allocator.sv
// first_fit_heap_allocator: first-fit allocator over an implicit list of chunk headers.
// Depends on ffha_pkg and ffha_ram (header store).
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command (allocate,
//   free, query), tdata the byte count and the payload offset. One result per
//   request leaves on m_axis: tuser carries the status, tdata the granted
//   offset and the heap-clear flag.
//   The header store is walked by a single next-chunk adder, one header per
//   cycle, through a RAM with registered read. A request walks the chunks
//   from header 0 until its command is settled or it runs off the end of the
//   list; a split or a successor merge adds a write step before the result,
//   and a zero-size allocate or a reserved command goes straight to the result.
//   s_axis_tready_o is high only while no request is in work, so one request
//   is processed at a time.
//   The result sits in an output register; a new request is accepted while it
//   waits. If the receiver still stalls when the next result is ready, the
//   block holds that result until the register frees up.
//   After reset the init state writes the initial free chunk to header 0;
//   tready rises in the cycle after it.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_UNITS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [12:0] request_bytes, [24:13] payload_offset, rest 0
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [11:0] granted_offset, [12] heap_clear, rest 0
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  localparam int unsigned AW = $clog2(HEAP_UNITS);          // size / index bits
  localparam int unsigned PW = AW + 1;                      // walk position, reaches HEAP_UNITS
  localparam int unsigned HW = AW + 1;                      // header: size, used flag
  localparam int unsigned UW = ffha_pkg::UnitW;
  localparam int unsigned CW = ((AW > UW) ? AW : UW) + 1;   // fit compare width
  localparam int unsigned OW = PW + 3;                      // payload byte offset width
  localparam int unsigned MW = (OW > ffha_pkg::OffW) ? OW : ffha_pkg::OffW;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_SPLIT = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [PW-1:0] p_q, p_d;
  logic [PW-1:0] base_q, base_d;
  logic [AW-1:0] sz_q, sz_d;
  logic [ffha_pkg::CmdW-1:0] cmd_q, cmd_d;
  logic [UW-1:0] units_q, units_d;
  logic [ffha_pkg::OffW-1:0] off_q, off_d;
  logic [ffha_pkg::StatW-1:0] status_q, status_d;
  logic [ffha_pkg::OffW-1:0] granted_q, granted_d;
  logic clear_q, clear_d;

  logic out_valid_q;
  logic [ffha_pkg::StatW-1:0] out_status_q;
  logic [ffha_pkg::OffW-1:0] out_granted_q;
  logic out_clear_q;
  logic fin_load;

  logic we;
  logic [AW-1:0] waddr;
  logic [HW-1:0] wdata;
  logic [HW-1:0] rdata;

  logic [AW-1:0] hsize;
  logic hused;
  logic [PW-1:0] p1, nxt, rest;
  logic fit, match, walk_end;
  logic [ffha_pkg::ReqW:0] req_sum;
  logic [ffha_pkg::ReqW-1:0] in_req;
  logic [MW-1:0] pay_off;

  assign in_req  = s_axis_tdata_i[12:0];
  assign req_sum = {1'b0, in_req} + (ffha_pkg::ReqW + 1)'(7);

  assign hsize    = rdata[HW-1:1];
  assign hused    = rdata[0];
  assign p1       = p_q + PW'(1);
  assign nxt      = p1 + PW'(hsize);                  // the shared next-chunk adder
  assign rest     = p1 + PW'(units_q);
  assign walk_end = p_q >= PW'(HEAP_UNITS);
  assign fit      = !hused && (CW'(hsize) >= (CW'(units_q) + CW'(1)));
  assign pay_off  = MW'({p1, 3'b000});
  assign match    = pay_off == MW'(off_q);

  always_comb begin
    state_d   = state_q;
    p_d       = p_q;
    base_d    = base_q;
    sz_d      = sz_q;
    cmd_d     = cmd_q;
    units_d   = units_q;
    off_d     = off_q;
    status_d  = status_q;
    granted_d = granted_q;
    clear_d   = clear_q;
    we        = 1'b0;
    waddr     = base_q[AW-1:0];
    wdata     = {sz_q, 1'b0};
    fin_load  = 1'b0;

    unique case (state_q)
      S_INIT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = {AW'(HEAP_UNITS - 1), 1'b0};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d     = s_axis_tuser_i;
          units_d   = req_sum[ffha_pkg::ReqW:3];
          off_d     = s_axis_tdata_i[24:13];
          p_d       = '0;
          status_d  = ffha_pkg::ST_OK;
          granted_d = '0;
          clear_d   = 1'b0;
          if (s_axis_tuser_i == ffha_pkg::CMD_ALLOC && in_req == '0) begin
            status_d = ffha_pkg::ST_ZERO;
            state_d  = S_FIN;
          end else if (s_axis_tuser_i == ffha_pkg::CMD_ALLOC ||
                       s_axis_tuser_i == ffha_pkg::CMD_FREE  ||
                       s_axis_tuser_i == ffha_pkg::CMD_QUERY) begin
            state_d = S_WALK;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_WALK: begin
        p_d = nxt;
        if (walk_end) begin
          state_d = S_FIN;
          case (cmd_q)
            ffha_pkg::CMD_ALLOC: status_d = ffha_pkg::ST_NOSPACE;
            ffha_pkg::CMD_FREE:  status_d = ffha_pkg::ST_NOTHEAP;
            default:             clear_d  = 1'b1;
          endcase
        end else begin
          case (cmd_q)
            ffha_pkg::CMD_ALLOC: begin
              if (fit) begin
                we        = 1'b1;
                waddr     = p_q[AW-1:0];
                wdata     = {AW'(units_q), 1'b1};
                granted_d = pay_off[ffha_pkg::OffW-1:0];
                base_d    = rest;
                sz_d      = hsize - AW'(units_q) - AW'(1);
                state_d   = (rest < PW'(HEAP_UNITS)) ? S_SPLIT : S_FIN;
              end
            end
            ffha_pkg::CMD_FREE: begin
              if (match) begin
                base_d = p_q;
                sz_d   = hsize;
                if (!hused) begin
                  status_d = ffha_pkg::ST_FREED;
                  state_d  = S_FIN;
                end else if (nxt < PW'(HEAP_UNITS)) begin
                  state_d = S_MERGE;                // successor header read next
                end else begin
                  we      = 1'b1;
                  waddr   = p_q[AW-1:0];
                  wdata   = {hsize, 1'b0};
                  state_d = S_FIN;
                end
              end
            end
            default: begin
              if (hused) begin
                clear_d = 1'b0;
                state_d = S_FIN;
              end
            end
          endcase
        end
      end
      S_MERGE: begin
        we      = 1'b1;
        wdata   = hused ? {sz_q, 1'b0} : {sz_q + hsize + AW'(1), 1'b0};
        state_d = S_FIN;
      end
      S_SPLIT: begin
        we      = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          fin_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  ffha_ram #(
    .WIDTH(HW),
    .DEPTH(HEAP_UNITS)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(p_d[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    base_q    <= base_d;
    sz_q      <= sz_d;
    cmd_q     <= cmd_d;
    units_q   <= units_d;
    off_q     <= off_d;
    status_q  <= status_d;
    granted_q <= granted_d;
    clear_q   <= clear_d;
    if (fin_load) begin
      out_status_q  <= status_q;
      out_granted_q <= granted_q;
      out_clear_q   <= clear_q;
    end
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {3'b000, out_clear_q, out_granted_q};

endmodule

>>> src/ffha_ram.sv
// ffha_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/ffha_checker.sv
// ffha_checker: port-level assertions for first_fit_heap_allocator, bound to the top level.
// Depends on ffha_pkg.
module ffha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // one request at a time: ready drops right after an accept
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while busy");

  // an offset is only granted on success
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[11:0] != 12'd0) |->
      m_axis_tuser_o == ffha_pkg::ST_OK)
    else $error("granted offset with error status");

  // heap clear never comes with an error
  a_clear_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[12] |->
      m_axis_tuser_o == ffha_pkg::ST_OK && m_axis_tdata_o[11:0] == 12'd0)
    else $error("heap clear with error status or grant");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
